[design/mmx_pkg.sv]
package mmx_pkg;

	localparam int CHANNELS   = 5;
	localparam int FIFO_DEPTH = 1024;
	localparam int MIN_MIXING = 2;

	localparam int CHAN_W = 3;
	localparam int SMP_W  = 16;
	localparam int CFG_W  = 3;
	localparam int DATA_W = 24;
	localparam int PAD_W  = DATA_W - CHAN_W - SMP_W;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int ACT_W = $clog2(CHANNELS + 1);
	localparam int IDX_W = $clog2(CHANNELS);

	typedef logic [CHANNELS-1:0][SMP_W-1:0] smp_arr_t;

	// one pending mix round between the fifo bank and the output stage
	typedef struct packed {
		logic                valid;
		logic [ACT_W-1:0]    act;
		logic [CHANNELS-1:0] byp;
		logic [SMP_W-1:0]    byp_data;
	} round_t;

endpackage

[design/mix_minus_audio_mixer_top.sv]
// mix-minus conference mixer
// s_axis carries one sample per request: tdata[2:0] channel, tdata[18:3] signed
// sample. each active channel (0 .. active_channels-1) has a 1024-deep fifo;
// samples for inactive channels or full fifos are dropped.
// once at least two channels are active and every active fifo holds a sample,
// one sample is popped from each and a round of results goes out on m_axis:
// one request per active channel in channel order, each the sum of the round
// minus that channel's own sample, tlast on the highest channel.
// cfg_wr_en/cfg_wr_data set active_channels (saturates at 5); write it only
// while the block is idle.
// throughput: one input per cycle while s_axis_tready is high; a round
// holds the output for active_channels results, one per cycle while
// m_axis_tready is high. the input that completes a round passes the
// input register, fifo ram read and result register before its first result.
// reset clears fifo counts and pointers at once, no clearing pass; ram
// contents are never used before they are written.
// when m_axis_tready is low the result holds; while a round goes out and the
// next is pending, s_axis_tready drops once the input register is full.
module mix_minus_audio_mixer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [mmx_pkg::DATA_W-1:0]  s_axis_tdata,   // channel, sample
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [mmx_pkg::DATA_W-1:0]  m_axis_tdata,   // out_channel, mixed_sample
	output logic                        m_axis_tlast,
	input  logic                        cfg_wr_en,
	input  logic [mmx_pkg::CFG_W-1:0]   cfg_wr_data
);

	import mmx_pkg::*;

	logic [CFG_W-1:0]  active_q;
	logic [ACT_W-1:0]  act;
	round_t            rnd;
	smp_arr_t          rd_data;
	logic              take;
	logic [CHAN_W-1:0] out_channel;
	logic [SMP_W-1:0]  out_mixed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_wr_en) begin
			active_q <= cfg_wr_data;
		end
	end

	assign act = (32'(active_q) > CHANNELS) ? ACT_W'(CHANNELS) : ACT_W'(active_q);

	mmx_fifo_bank u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.act       (act),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_channel(s_axis_tdata[CHAN_W-1:0]),
		.in_sample (s_axis_tdata[CHAN_W+SMP_W-1:CHAN_W]),
		.take      (take),
		.rnd       (rnd),
		.rd_data   (rd_data)
	);

	mmx_mix_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.rnd        (rnd),
		.rd_data    (rd_data),
		.take       (take),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_channel(out_channel),
		.out_mixed  (out_mixed),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {PAD_W'(0), out_mixed, out_channel};

`ifndef SYNTHESIS
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> 32'(m_axis_tdata[CHAN_W-1:0]) < CHANNELS)
		else $error("result channel out of range");

	a_chan_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tvalid && (m_axis_tdata[CHAN_W-1:0] ==
			$past(m_axis_tdata[CHAN_W-1:0]) + CHAN_W'(1)))
		else $error("round did not advance to next channel");

	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !$past(m_axis_tvalid) |-> m_axis_tdata[CHAN_W-1:0] == '0)
		else $error("round did not start at channel zero");
`endif

endmodule

[design/mmx_ram.sv]
module mmx_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/mmx_fifo_bank.sv]
module mmx_fifo_bank (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mmx_pkg::ACT_W-1:0]    act,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mmx_pkg::CHAN_W-1:0]   in_channel,
	input  logic [mmx_pkg::SMP_W-1:0]    in_sample,
	input  logic                         take,
	output mmx_pkg::round_t              rnd,
	output mmx_pkg::smp_arr_t            rd_data
);

	import mmx_pkg::*;

	logic                valid_s1;
	logic [CHAN_W-1:0]   ch_s1;
	logic [SMP_W-1:0]    smp_s1;
	logic                valid_s2;
	logic [ACT_W-1:0]    act_s2;
	logic [CHANNELS-1:0] byp_s2;
	logic [SMP_W-1:0]    byp_data_s2;

	logic [CNT_W-1:0]    fill_q [CHANNELS];
	logic [PTR_W-1:0]    rptr_q [CHANNELS];
	logic [PTR_W-1:0]    wptr_q [CHANNELS];

	logic [CHANNELS-1:0] act_vec;
	logic [CHANNELS-1:0] wr_vec;
	logic [CHANNELS-1:0] avail;
	logic [CHANNELS-1:0] pop;
	logic [CHANNELS-1:0] byp_vec;
	logic                round;
	logic                s1_fire;

	assign s1_fire  = valid_s1 && (!valid_s2 || take);
	assign in_ready = !valid_s1 || s1_fire;
	assign round    = (act >= ACT_W'(MIN_MIXING)) && (&(avail | ~act_vec));
	assign rnd      = {valid_s2, act_s2, byp_s2, byp_data_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1  <= in_channel;
			smp_s1 <= in_sample;
		end
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
		assign act_vec[i] = ACT_W'(i) < act;
		assign wr_vec[i]  = valid_s1 && (ch_s1 == CHAN_W'(i)) && act_vec[i]
			&& (fill_q[i] != CNT_W'(FIFO_DEPTH));
		assign avail[i]   = (fill_q[i] != '0) || wr_vec[i];
		assign pop[i]     = round && act_vec[i];
		// an empty fifo that gets its sample and pops it at once reads past the ram
		assign byp_vec[i] = wr_vec[i] && (fill_q[i] == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fill_q[i] <= '0;
				rptr_q[i] <= '0;
				wptr_q[i] <= '0;
			end else if (s1_fire) begin
				if (wr_vec[i] && !pop[i]) begin
					fill_q[i] <= fill_q[i] + CNT_W'(1);
				end else if (!wr_vec[i] && pop[i]) begin
					fill_q[i] <= fill_q[i] - CNT_W'(1);
				end
				if (wr_vec[i]) begin
					wptr_q[i] <= (wptr_q[i] == PTR_W'(FIFO_DEPTH - 1)) ? '0
						: wptr_q[i] + PTR_W'(1);
				end
				if (pop[i]) begin
					rptr_q[i] <= (rptr_q[i] == PTR_W'(FIFO_DEPTH - 1)) ? '0
						: rptr_q[i] + PTR_W'(1);
				end
			end
		end

		mmx_ram #(
			.DEPTH(FIFO_DEPTH),
			.WIDTH(SMP_W)
		) u_ram (
			.clk    (clk),
			.wr_en  (s1_fire && wr_vec[i]),
			.wr_addr(wptr_q[i]),
			.wr_data(smp_s1),
			.rd_en  (s1_fire && pop[i]),
			.rd_addr(rptr_q[i]),
			.rd_data(rd_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_fire) begin
			valid_s2 <= round;
		end else if (take) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			act_s2      <= act;
			byp_s2      <= byp_vec;
			byp_data_s2 <= smp_s1;
		end
	end

endmodule

[design/mmx_mix_out.sv]
module mmx_mix_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mmx_pkg::round_t              rnd,
	input  mmx_pkg::smp_arr_t            rd_data,
	output logic                         take,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mmx_pkg::CHAN_W-1:0]   out_channel,
	output logic [mmx_pkg::SMP_W-1:0]    out_mixed,
	output logic                         out_last
);

	import mmx_pkg::*;

	logic                busy_q;
	logic [IDX_W-1:0]    idx_q;
	logic [ACT_W-1:0]    cnt_q;
	logic [SMP_W-1:0]    res_q [CHANNELS];

	logic [SMP_W-1:0]    popped [CHANNELS];
	logic [SMP_W-1:0]    sum;
	logic                last_beat;
	logic                load_ok;

	assign last_beat   = ACT_W'(idx_q) == cnt_q - ACT_W'(1);
	assign load_ok     = !busy_q || (out_ready && last_beat);
	assign take        = rnd.valid && load_ok;
	assign out_valid   = busy_q;
	assign out_channel = CHAN_W'(idx_q);
	assign out_mixed   = res_q[idx_q];
	assign out_last    = last_beat;

	// sum wraps to sample width, inactive channels count as zero
	always_comb begin
		sum = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			popped[i] = rnd.byp[i] ? rnd.byp_data : rd_data[i];
			if (ACT_W'(i) < rnd.act) begin
				sum = sum + popped[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			cnt_q  <= rnd.act;
		end else if (busy_q && out_ready) begin
			if (last_beat) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < CHANNELS; i++) begin
				res_q[i] <= sum - popped[i];
			end
		end
	end

endmodule

[dv/mix_minus_audio_mixer_top_test.sv]
module mix_minus_audio_mixer_top_test;
	import mmx_pkg::*;

	typedef struct packed {
		logic [CHAN_W-1:0]       chan;
		logic signed [SMP_W-1:0] smp;
	} sample_req_t;

	typedef struct packed {
		logic [CHAN_W-1:0]       chan;
		logic signed [SMP_W-1:0] mixed;
		logic                    last;
	} mix_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [DATA_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;
	logic              cfg_wr_en;
	logic [CFG_W-1:0]  cfg_wr_data;

	// mixer state as seen by the predictor
	logic [SMP_W-1:0] chan_ring [CHANNELS][FIFO_DEPTH];
	int               ring_rd [CHANNELS];
	int               ring_wr [CHANNELS];
	int               ring_fill [CHANNELS];
	logic [CFG_W-1:0] mix_active;

	mix_result_t due_mixes [$];
	sample_req_t sample_backlog [$];

	logic req_taken;
	logic hold_long;
	int   err_cnt;
	int   accepted_cnt;
	int   gap_left;
	int   burst_left;
	int   win_left;
	int   rdy_mode;

	mix_minus_audio_mixer_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// queue the sample, pop a round if >= 2 channels are active and all have one
	function automatic void enqueue_and_mix(input sample_req_t req);
		int               act;
		int               i;
		logic [SMP_W-1:0] sum;
		logic [SMP_W-1:0] popped [CHANNELS];
		mix_result_t      res;
		act = (mix_active > CHANNELS) ? CHANNELS : int'(mix_active);
		if (req.chan < act && ring_fill[req.chan] < FIFO_DEPTH) begin
			chan_ring[req.chan][ring_wr[req.chan]] = req.smp;
			ring_wr[req.chan] = (ring_wr[req.chan] + 1) % FIFO_DEPTH;
			ring_fill[req.chan]++;
		end
		if (act < MIN_MIXING)
			return;
		for (i = 0; i < act; i++)
			if (ring_fill[i] == 0)
				return;
		sum = '0;
		for (i = 0; i < act; i++) begin
			popped[i] = chan_ring[i][ring_rd[i]];
			ring_rd[i] = (ring_rd[i] + 1) % FIFO_DEPTH;
			ring_fill[i]--;
			sum += popped[i];
		end
		for (i = 0; i < act; i++) begin
			res.chan  = CHAN_W'(i);
			res.mixed = sum - popped[i];
			res.last  = (i == act - 1);
			due_mixes.push_back(res);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : mon
		mix_result_t got;
		mix_result_t want;
		sample_req_t req;
		if (!arst_n) begin
			req_taken <= 1'b0;
			mix_active = '0;
			for (int c = 0; c < CHANNELS; c++) begin
				ring_rd[c]   = 0;
				ring_wr[c]   = 0;
				ring_fill[c] = 0;
			end
		end else begin
			if (cfg_wr_en)
				mix_active = cfg_wr_data;
			req_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				req.chan = s_axis_tdata[CHAN_W-1:0];
				req.smp  = s_axis_tdata[CHAN_W +: SMP_W];
				enqueue_and_mix(req);
				accepted_cnt++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.chan  = m_axis_tdata[CHAN_W-1:0];
				got.mixed = m_axis_tdata[CHAN_W +: SMP_W];
				got.last  = m_axis_tlast;
				if (due_mixes.size() == 0) begin
					if (err_cnt < 10)
						$display("unexpected result: chan %0d mixed %0d last %0d",
							got.chan, got.mixed, got.last);
					err_cnt++;
				end else begin
					want = due_mixes[0];
					due_mixes.delete(0);
					if (got != want) begin
						if (err_cnt < 10)
							$display("mismatch: exp %0d %0d %0d, got %0d %0d %0d",
								want.chan, want.mixed, want.last,
								got.chan, got.mixed, got.last);
						err_cnt++;
					end
				end
			end
		end
	end

	// sender: bursts of requests with random gaps, valid held until taken
	always @(negedge clk) begin : drv
		if (req_taken)
			sample_backlog.delete(0);
		if (!s_axis_tvalid || req_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (sample_backlog.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {{PAD_W{1'b0}}, sample_backlog[0].smp,
					sample_backlog[0].chan};
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: ready pattern changes mode every window
	always @(negedge clk) begin : rcv
		if (win_left == 0) begin
			win_left = $urandom_range(16, 96);
			rdy_mode = $urandom_range(0, 3);
		end
		win_left--;
		if (hold_long)
			m_axis_tready <= 1'b0;
		else
			case (rdy_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= $urandom_range(0, 1);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= ($urandom_range(0, 7) != 0);
			endcase
	end

	// long output stall so rounds pile up and the input backs off
	initial begin : hold_off
		hold_long = 1'b0;
		wait (accepted_cnt >= 50);
		@(negedge clk);
		hold_long <= 1'b1;
		repeat (400) @(negedge clk);
		hold_long <= 1'b0;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	task automatic push_sample(input int chan, input logic [SMP_W-1:0] smp);
		sample_req_t req;
		req.chan = CHAN_W'(chan);
		req.smp  = smp;
		sample_backlog.push_back(req);
	endtask

	task automatic write_active(input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= val;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// wait until every request is taken and every result is back
	task automatic settle();
		while (sample_backlog.size() != 0 || s_axis_tvalid || due_mixes.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// mostly complete rounds in shuffled channel order, some stray samples
	task automatic random_phase(input logic [CFG_W-1:0] val, input int n);
		int eff;
		int cnt;
		int j;
		int tmp;
		int ord [CHANNELS];
		write_active(val);
		eff = (val > CHANNELS) ? CHANNELS : int'(val);
		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(0, 6) == 0) begin
				push_sample($urandom_range(0, 7), rand_sample());
			end else begin
				for (int i = 0; i < eff; i++)
					ord[i] = i;
				for (int i = eff - 1; i > 0; i--) begin
					j      = $urandom_range(0, i);
					tmp    = ord[i];
					ord[i] = ord[j];
					ord[j] = tmp;
				end
				for (int i = 0; i < eff; i++)
					push_sample(ord[i], rand_sample());
				cnt += eff;
			end
		end
		settle();
	endtask

	initial begin : stim
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		err_cnt       = 0;
		accepted_cnt  = 0;
		gap_left      = 0;
		burst_left    = 1;
		win_left      = 0;
		rdy_mode      = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// nothing active: every sample dropped
		write_active(0);
		push_sample(0, 16'h1234);
		push_sample(3, 16'hFFFF);
		settle();

		// one channel: channel 0 queues, no mixing
		write_active(1);
		push_sample(0, 16'h7FFF);
		push_sample(0, 16'h8000);
		push_sample(1, 16'h0005);
		settle();

		// all five, with the queued channel 0 samples and stray channels
		write_active(5);
		push_sample(1, 16'h7FFF);
		push_sample(7, 16'h0064);
		push_sample(2, 16'h7FFF);
		push_sample(5, 16'h0001);
		push_sample(3, 16'h8000);
		push_sample(6, 16'hFFFF);
		push_sample(4, 16'hFFFF);
		push_sample(4, 16'h0000);
		push_sample(3, 16'h0000);
		push_sample(2, 16'h8000);
		push_sample(1, 16'h0001);
		push_sample(0, 16'h0000);
		push_sample(1, 16'hFFFF);
		push_sample(2, 16'hFFFF);
		push_sample(3, 16'h7FFF);
		push_sample(4, 16'h5555);
		settle();

		random_phase(5, 70);
		random_phase(2, 50);
		random_phase(7, 50);
		random_phase(3, 50);
		random_phase(6, 50);
		random_phase(4, 50);

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
